FILE: rtl/c_esc_pkg.sv
// shared types and character codes for the c escape sequence decoder
`timescale 1ns / 1ps

package c_esc_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       nonstandard_escape;
    logic       last_out;
  } out_item_t;

  // one queue entry: one or two results decoded from one request
  typedef struct packed {
    logic      two;
    out_item_t r1;
    out_item_t r0;
  } cmd_t;

  localparam logic [7:0] NEWLINE_RESET = 8'd10;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;

  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

endpackage

FILE: rtl/c_escape_sequence_decoder.sv
// top level of the c string literal escape decoder
`timescale 1ns / 1ps

// channel   signals                        payload
// in        in_valid / in_stall            in_data: char_in, last_in
// out       out_valid / out_stall          out_data: out_byte, byte_valid,
//                                            nonstandard_escape, last_out
// cfg       cfg_we                         cfg_wdata: newline_code
//
// one raw byte is taken per cycle while in_stall is low; it passes the queue
// and the output register on its way out. results leave one per cycle while
// out_stall is low; the queue absorbs the extra results of two-result bytes.
// in_stall rises only when the queue of QUEUE_DEPTH entries is full.
// synchronous reset clears decode state, queue and output; newline code is 10.

module c_escape_sequence_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  c_esc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c_esc_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  logic            push, pop, q_full, q_empty;
  c_esc_pkg::cmd_t push_data, q_data;

  c_esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  c_esc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  c_esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/c_esc_front.sv
// front end: takes raw bytes, tracks escape state, queues decoded results
`timescale 1ns / 1ps

module c_esc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  c_esc_pkg::in_item_t in_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output logic                push,
  output c_esc_pkg::cmd_t     push_data,
  input  logic                q_full
);

  typedef enum logic [1:0] {M_IDLE, M_BODY, M_ESC, M_OCT} mode_t;

  mode_t      mode, mode_next;
  logic [1:0] cnt, cnt_next;
  logic [7:0] acc, acc_next;
  logic [7:0] quote, quote_next;
  logic [7:0] newline_code;

  logic                 accept;
  logic [1:0]           n;
  c_esc_pkg::out_item_t res [2];

  function automatic c_esc_pkg::out_item_t mk(input logic [7:0] b, input logic v,
                                              input logic ns);
    c_esc_pkg::out_item_t r;
    r.out_byte           = b;
    r.byte_valid         = v;
    r.nonstandard_escape = ns;
    r.last_out           = 1'b0;
    return r;
  endfunction

  function automatic c_esc_pkg::out_item_t esc_map(input logic [7:0] c, input logic [7:0] nl);
    c_esc_pkg::out_item_t r;
    unique case (c) inside
      c_esc_pkg::CH_DQUOTE, c_esc_pkg::CH_SQUOTE, c_esc_pkg::CH_BSLASH: r = mk(c, 1'b1, 1'b0);
      c_esc_pkg::CH_A: r = mk(c_esc_pkg::CODE_BEL, 1'b1, 1'b0);
      c_esc_pkg::CH_B: r = mk(c_esc_pkg::CODE_BS, 1'b1, 1'b0);
      c_esc_pkg::CH_F: r = mk(c_esc_pkg::CODE_FF, 1'b1, 1'b0);
      c_esc_pkg::CH_N: r = mk(nl, 1'b1, 1'b0);
      c_esc_pkg::CH_R: r = mk(c_esc_pkg::CODE_CR, 1'b1, 1'b0);
      c_esc_pkg::CH_T: r = mk(c_esc_pkg::CODE_HT, 1'b1, 1'b0);
      c_esc_pkg::CH_V: r = mk(c_esc_pkg::CODE_VT, 1'b1, 1'b0);
      default:         r = mk(c, 1'b1, 1'b1);
    endcase
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    logic [7:0] c;
    logic       last;
    logic       is_oct;
    logic       done;
    c          = in_data.char_in;
    last       = in_data.last_in;
    is_oct     = (c[7:3] == 5'b00110);
    done       = 1'b0;
    mode_next  = mode;
    cnt_next   = cnt;
    acc_next   = acc;
    quote_next = quote;
    n          = 2'd0;
    res[0]     = '0;
    res[1]     = '0;

    if (mode == M_IDLE) begin
      quote_next = c;
      mode_next  = M_BODY;
    end else if (last && c == quote) begin
      if (mode == M_OCT) begin
        res[n[0]] = mk(acc, 1'b1, 1'b0);
        n         = n + 2'd1;
        mode_next = M_BODY;
      end
    end else begin
      if (mode == M_OCT) begin
        if (is_oct) begin
          acc_next = {acc[4:0], c[2:0]};
          cnt_next = cnt + 2'd1;
          // third digit closes the escape
          if (cnt_next == c_esc_pkg::OCT_MAX_DIGITS) begin
            res[n[0]] = mk(acc_next, 1'b1, 1'b0);
            n         = n + 2'd1;
            acc_next  = '0;
            cnt_next  = '0;
            mode_next = M_BODY;
          end
          done = 1'b1;
        end else begin
          res[n[0]] = mk(acc, 1'b1, 1'b0);
          n         = n + 2'd1;
          acc_next  = '0;
          cnt_next  = '0;
          mode_next = M_BODY;
        end
      end
      if (!done) begin
        if (mode_next == M_ESC) begin
          if (is_oct) begin
            acc_next  = {5'd0, c[2:0]};
            cnt_next  = 2'd1;
            mode_next = M_OCT;
          end else begin
            res[n[0]] = esc_map(c, newline_code);
            n         = n + 2'd1;
            mode_next = M_BODY;
          end
        end else if (c == c_esc_pkg::CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          res[n[0]] = mk(c, 1'b1, 1'b0);
          n         = n + 2'd1;
        end
      end
    end

    if (last) begin
      // pending octal flushes at the end; a dangling backslash is dropped
      if (mode_next == M_OCT) begin
        res[n[0]] = mk(acc_next, 1'b1, 1'b0);
        n         = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[0] = mk(8'd0, 1'b0, 1'b0);
        n      = 2'd1;
      end
      if (n == 2'd2) begin
        res[1].last_out = 1'b1;
      end else begin
        res[0].last_out = 1'b1;
      end
      mode_next = M_IDLE;
      cnt_next  = '0;
      acc_next  = '0;
    end
  end

  assign push         = accept && (n != 2'd0);
  assign push_data.two = (n == 2'd2);
  assign push_data.r0  = res[0];
  assign push_data.r1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      cnt          <= '0;
      acc          <= '0;
      quote        <= '0;
      newline_code <= c_esc_pkg::NEWLINE_RESET;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        cnt   <= cnt_next;
        acc   <= acc_next;
        quote <= quote_next;
      end
      if (cfg_we) begin
        newline_code <= cfg_wdata;
      end
    end
  end

endmodule

FILE: rtl/c_esc_fifo.sv
// small queue of decoded result pairs between front and back
`timescale 1ns / 1ps

module c_esc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  c_esc_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output c_esc_pkg::cmd_t pop_data,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  c_esc_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/c_esc_back.sv
// back end: unpacks queued pairs, one result per cycle unless stalled
`timescale 1ns / 1ps

module c_esc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  c_esc_pkg::cmd_t      q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c_esc_pkg::out_item_t out_data
);

  logic                 pend_valid;
  c_esc_pkg::out_item_t pend;
  logic                 load;

  // output register free or draining this cycle
  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_data <= pend;
      end else if (!q_empty) begin
        out_data <= q_data.r0;
        pend     <= q_data.r1;
      end
    end
  end

endmodule

FILE: rtl/c_esc_checker.sv
// port-level checks for the c escape sequence decoder
`timescale 1ns / 1ps

module c_esc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input c_esc_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // bare end marker is all zero and closes the literal
  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |->
      out_data.last_out && out_data.out_byte == 8'd0 && !out_data.nonstandard_escape)
    else $error("malformed end marker");

  // warning only rides on a real byte
  a_warn_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.nonstandard_escape |-> out_data.byte_valid)
    else $error("warning without byte");

endmodule

bind c_escape_sequence_decoder c_esc_checker u_chk (.*);

FILE: bench/tb_c_escape_sequence_decoder.sv
// self-checking testbench for the c escape sequence decoder
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder;
  import c_esc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_REQUESTS = 125;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] KNOWN_ESC [10] = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V,
                                            CH_DQUOTE, CH_SQUOTE, CH_BSLASH};

  typedef enum logic [1:0] {EXPECT_QUOTE, IN_BODY, AFTER_BSLASH, IN_OCTAL} dec_mode_t;

  class escape_scoreboard;
    logic [7:0] newline_code;
    dec_mode_t  mode;
    logic [1:0] oct_digits;
    logic [8:0] oct_value;
    logic [7:0] quote_char;
    out_item_t  step_res [2];
    int         step_n;
    out_item_t  due_results [$];
    int         errors;
    int         requests;
    int         results_checked;
    int         unknown_seen;
    int         markers_seen;

    function new();
      newline_code    = NEWLINE_RESET;
      mode            = EXPECT_QUOTE;
      oct_digits      = '0;
      oct_value       = '0;
      quote_char      = '0;
      errors          = 0;
      requests        = 0;
      results_checked = 0;
      unknown_seen    = 0;
      markers_seen    = 0;
    endfunction

    function bit is_octal_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function void add_result(logic [7:0] b, logic valid, logic nonstd);
      if (step_n < 2) begin
        step_res[step_n] = '{out_byte: b, byte_valid: valid, nonstandard_escape: nonstd,
                             last_out: 1'b0};
        step_n++;
      end
    endfunction

    function void flush_octal();
      add_result(oct_value[7:0], 1'b1, 1'b0);
      oct_value  = '0;
      oct_digits = '0;
      mode       = IN_BODY;
    endfunction

    function void decode_escape(logic [7:0] c);
      case (c)
        CH_DQUOTE, CH_SQUOTE, CH_BSLASH: add_result(c, 1'b1, 1'b0);
        CH_A: add_result(CODE_BEL, 1'b1, 1'b0);
        CH_B: add_result(CODE_BS, 1'b1, 1'b0);
        CH_F: add_result(CODE_FF, 1'b1, 1'b0);
        CH_N: add_result(newline_code, 1'b1, 1'b0);
        CH_R: add_result(CODE_CR, 1'b1, 1'b0);
        CH_T: add_result(CODE_HT, 1'b1, 1'b0);
        CH_V: add_result(CODE_VT, 1'b1, 1'b0);
        default: add_result(c, 1'b1, 1'b1);
      endcase
    endfunction

    // works out the results of one accepted request and queues them
    function void predict_decode(in_item_t req);
      logic [7:0] c;
      bit         done;
      c      = req.char_in;
      done   = 1'b0;
      step_n = 0;
      requests++;
      if (mode == EXPECT_QUOTE) begin
        quote_char = c;
        mode       = IN_BODY;
      end else if (req.last_in && c == quote_char) begin
        if (mode == IN_OCTAL) flush_octal();
      end else begin
        if (mode == IN_OCTAL) begin
          if (is_octal_digit(c)) begin
            oct_value  = {oct_value[5:0], 3'b000} + 9'(c - CH_ZERO);
            oct_digits = oct_digits + 2'd1;
            if (oct_digits == OCT_MAX_DIGITS) flush_octal();
            done = 1'b1;
          end else begin
            flush_octal();
          end
        end
        if (!done) begin
          if (mode == AFTER_BSLASH) begin
            if (is_octal_digit(c)) begin
              oct_value  = 9'(c - CH_ZERO);
              oct_digits = 2'd1;
              mode       = IN_OCTAL;
            end else begin
              decode_escape(c);
              mode = IN_BODY;
            end
          end else if (c == CH_BSLASH) begin
            mode = AFTER_BSLASH;
          end else begin
            add_result(c, 1'b1, 1'b0);
          end
        end
      end
      if (req.last_in) begin
        if (mode == IN_OCTAL) flush_octal();
        // nothing decoded on the final byte: bare end marker
        if (step_n == 0) add_result(8'h00, 1'b0, 1'b0);
        step_res[step_n - 1].last_out = 1'b1;
        mode       = EXPECT_QUOTE;
        oct_digits = '0;
        oct_value  = '0;
      end
      for (int i = 0; i < step_n; i++) due_results.push_back(step_res[i]);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: out_byte 0x%0h last_out %0b",
               got.out_byte, got.last_out);
        errors++;
      end else if ($isunknown(got)) begin
        want = due_results.pop_front();
        $error("result carries unknown bits: 0x%0h", got);
        errors++;
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (want.nonstandard_escape) unknown_seen++;
        if (!want.byte_valid) markers_seen++;
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("byte_valid", want.byte_valid, got.byte_valid);
        compare_field("nonstandard_escape", want.nonstandard_escape, got.nonstandard_escape);
        compare_field("last_out", want.last_out, got.last_out);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int literals_sent = 0;
  int bytes_sent    = 0;

  logic [7:0] lit [$];
  escape_scoreboard sb;

  c_escape_sequence_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.predict_decode(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles, %0d results outstanding",
             quiet_cycles, sb.pending());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: ch, last_in: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_literal();
    foreach (lit[i]) send_request(lit[i], i == lit.size() - 1);
    literals_sent++;
  endtask

  // hold requests back until every decoded byte is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_newline(input logic [7:0] code);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    sb.newline_code = code;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_token(input logic [7:0] quote);
    case ($urandom_range(6))
      0, 1: lit.push_back(8'($urandom()));
      2: begin
        lit.push_back(CH_BSLASH);
        lit.push_back(KNOWN_ESC[$urandom_range(9)]);
      end
      3: begin
        lit.push_back(CH_BSLASH);
        repeat ($urandom_range(3, 1)) lit.push_back(CH_ZERO + 8'($urandom_range(7)));
      end
      4: begin
        lit.push_back(CH_BSLASH);
        lit.push_back($urandom_range(1) ? 8'($urandom()) : CH_EIGHT + 8'($urandom_range(1)));
      end
      5: begin
        // octal run followed by a digit, so the escape closes after three
        lit.push_back(CH_BSLASH);
        repeat (4) lit.push_back(CH_ZERO + 8'($urandom_range(7)));
      end
      default: lit.push_back(quote);
    endcase
  endtask

  task automatic build_literal();
    logic [7:0] quote;
    lit.delete();
    if ($urandom_range(99) < 10) begin
      // noise: raw bytes with no structure
      repeat ($urandom_range(10, 1)) lit.push_back(8'($urandom()));
    end else begin
      if ($urandom_range(9) < 8) quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      else quote = 8'($urandom());
      lit.push_back(quote);
      repeat ($urandom_range(8)) add_token(quote);
      case ($urandom_range(9))
        0: ;
        1: begin
          lit.push_back(CH_BSLASH);
          lit.push_back(quote);
        end
        2: lit.push_back(CH_BSLASH);
        3: begin
          lit.push_back(CH_BSLASH);
          lit.push_back(CH_ZERO + 8'($urandom_range(7)));
        end
        default: lit.push_back(quote);
      endcase
    end
  endtask

  initial begin
    logic [7:0] codes [4];
    int         idle_pcts [4];
    int         stall_pcts [4];
    int         phase_start;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part runs with the newline code left at its reset value
    send_idle_pct = 27;
    stall_pct     = 27;
    lit = '{CH_DQUOTE};
    send_literal();
    lit = '{CH_DQUOTE, CH_BSLASH, CH_A, CH_BSLASH, CH_B, CH_BSLASH, CH_F, CH_BSLASH, CH_N,
            CH_BSLASH, CH_R, CH_BSLASH, CH_T, CH_BSLASH, CH_V, CH_DQUOTE};
    send_literal();
    // quote escapes, wrapped octal, octal cut by 8, digit escape 9, extreme bytes,
    // a bare quote in the body and a backslash just before the terminator
    lit = '{CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_BSLASH,
            CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN, CH_BSLASH, CH_ONE, CH_EIGHT,
            CH_BSLASH, CH_NINE, 8'hff, 8'h00, CH_SQUOTE, CH_BSLASH, CH_SQUOTE};
    send_literal();
    // unterminated, octal still open at the end
    lit = '{CH_DQUOTE, CH_BSLASH, CH_ONE, CH_TWO};
    send_literal();

    codes      = '{8'h00, 8'hff, 8'($urandom_range(254, 1)), NEWLINE_RESET};
    idle_pcts  = '{0, 85, 0, 27};
    stall_pcts = '{0, 0, 85, 27};
    for (int ph = 0; ph < 4; ph++) begin
      write_newline(codes[ph]);
      send_idle_pct = idle_pcts[ph];
      stall_pct     = stall_pcts[ph];
      phase_start   = bytes_sent;
      while (bytes_sent - phase_start < PHASE_REQUESTS) begin
        build_literal();
        send_literal();
      end
    end

    settle();
    $display("decoded %0d literals from %0d raw bytes into %0d results", literals_sent,
             bytes_sent, sb.results_checked);
    $display("%0d unknown escapes, %0d bare end markers, four newline codes incl. 0 and 255",
             sb.unknown_seen, sb.markers_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/c_esc_pkg.sv
rtl/c_esc_front.sv
rtl/c_esc_fifo.sv
rtl/c_esc_back.sv
rtl/c_escape_sequence_decoder.sv
rtl/c_esc_checker.sv
bench/tb_c_escape_sequence_decoder.sv
